>>> sv/npq_pkg.sv
// ----------------------------------------------------------------------------
// npq_pkg: shared types and constants of the nearest palette color quantizer
// Holds the palette depth, field widths, codes, the beat that moves along
// the cell row, and the luma constants of the gray path.
// ----------------------------------------------------------------------------
package npq_pkg;

  // Number of palette entries, one per cell (2 to 256).
  localparam int PAL_DEPTH = 256;
  localparam int IDX_W     = $clog2(PAL_DEPTH);

  localparam int CHAN_W = 8;
  localparam int ENT_W  = 8;
  localparam int CIDX_W = 8;
  localparam int SIZE_W = 9;
  localparam int DIST_W = 10;   // three channel differences, at most 765
  localparam int LUMA_W = 18;   // 299R + 587G + 114B, at most 255000
  localparam int LVL_W  = 4;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_ADDR_W-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SIZE = 1'b1;

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_GRAY    = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  localparam int LUMA_R   = 299;
  localparam int LUMA_G   = 587;
  localparam int LUMA_B   = 114;
  localparam int GRAY_DIV = 17000;
  localparam int GRAY_LEVELS = 16;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

  // Payload of one beat as it moves from cell to cell.
  typedef struct packed {
    kind_t              kind;
    logic [ENT_W-1:0]   entry;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CIDX_W-1:0]  best_idx;
    logic [DIST_W-1:0]  best_dist;
  } link_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> sv/npq_cell.sv
// ----------------------------------------------------------------------------
// npq_cell: one palette cell of the search row
// Stores one palette entry, captures it when a matching write beat passes,
// and updates the running best match of each pixel beat handed through.
// ----------------------------------------------------------------------------
module npq_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [npq_pkg::IDX_W-1:0]    cell_idx,
  input  logic [npq_pkg::SIZE_W-1:0]   palette_size,
  input  logic                         in_valid,
  input  npq_pkg::link_t               in_link,
  output logic                         out_valid,
  output npq_pkg::link_t               out_link
);

  logic [npq_pkg::CHAN_W-1:0] ent_red_r, ent_green_r, ent_blue_r;
  logic                       valid_r;
  npq_pkg::link_t             link_r, link_nxt;
  logic [npq_pkg::DIST_W-1:0] cand_dist;
  logic                       active, take;

  always_comb begin
    cand_dist = npq_pkg::DIST_W'(npq_pkg::abs_diff(ent_red_r, in_link.red))
              + npq_pkg::DIST_W'(npq_pkg::abs_diff(ent_green_r, in_link.green))
              + npq_pkg::DIST_W'(npq_pkg::abs_diff(ent_blue_r, in_link.blue));
    active = npq_pkg::SIZE_W'(cell_idx) < palette_size;
    // The lowest cell, if active, takes the pixel whatever its distance; later
    // cells only on a strictly smaller distance, so ties keep the lower index.
    take = (in_link.kind == npq_pkg::KIND_PIXEL) && active &&
           ((cell_idx == '0) || (cand_dist < in_link.best_dist));
    link_nxt = in_link;
    if (take) begin
      link_nxt.best_idx  = npq_pkg::CIDX_W'(cell_idx);
      link_nxt.best_dist = cand_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      link_r <= link_nxt;
    end
    if (adv && in_valid && (in_link.kind == npq_pkg::KIND_WRITE) &&
        (in_link.entry == npq_pkg::ENT_W'(cell_idx))) begin
      ent_red_r   <= in_link.red;
      ent_green_r <= in_link.green;
      ent_blue_r  <= in_link.blue;
    end
  end

  assign out_valid = valid_r;
  assign out_link  = link_r;

endmodule

>>> sv/npq_out.sv
// ----------------------------------------------------------------------------
// npq_out: result stage behind the cell row
// Drops write beats, computes the luma of each pixel, and holds in the output
// register one of sixteen gray levels (gray mode) or the best index (palette).
// ----------------------------------------------------------------------------
module npq_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        mode,
  input  logic                        in_valid,
  input  npq_pkg::link_t              in_link,
  output logic                        adv,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [npq_pkg::CIDX_W-1:0]  out_tdata
);

  logic                        t_valid_r;
  logic [npq_pkg::CIDX_W-1:0]  t_idx_r;
  logic [npq_pkg::LUMA_W-1:0]  t_luma_r, luma_nxt;
  logic [npq_pkg::LVL_W-1:0]   level;
  logic                        o_valid_r, out_load;
  logic [npq_pkg::CIDX_W-1:0]  o_data_r, o_data_nxt;

  assign out_load = t_valid_r && (!o_valid_r || out_tready);
  assign adv      = !t_valid_r || !o_valid_r || out_tready;

  always_comb begin
    luma_nxt = npq_pkg::LUMA_W'(in_link.red)   * npq_pkg::LUMA_W'(npq_pkg::LUMA_R)
             + npq_pkg::LUMA_W'(in_link.green) * npq_pkg::LUMA_W'(npq_pkg::LUMA_G)
             + npq_pkg::LUMA_W'(in_link.blue)  * npq_pkg::LUMA_W'(npq_pkg::LUMA_B);
  end

  // Floor division by the level step: count the thresholds reached.
  always_comb begin
    level = '0;
    for (int k = 1; k < npq_pkg::GRAY_LEVELS; k++) begin
      if (t_luma_r >= npq_pkg::LUMA_W'(k * npq_pkg::GRAY_DIV)) begin
        level = npq_pkg::LVL_W'(k);
      end
    end
    o_data_nxt = (mode == npq_pkg::MODE_GRAY) ? npq_pkg::CIDX_W'(level) : t_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        t_valid_r <= in_valid && (in_link.kind == npq_pkg::KIND_PIXEL);
      end
      if (out_load) begin
        o_valid_r <= 1'b1;
      end else if (out_tready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_idx_r  <= in_link.best_idx;
      t_luma_r <= luma_nxt;
    end
    if (out_load) begin
      o_data_r <= o_data_nxt;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_data_r;

endmodule

>>> sv/nearest_palette_color_quantizer.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_quantizer: systolic nearest palette color search
// Maps 24-bit pixels to the index of the closest palette entry (sum of
// absolute channel differences, lowest index on ties) or to a 16-level gray.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  -------  ---------  -----------------------------------------------------
//  in_      slave      tuser: kind; tdata: entry, red, green, blue (32 bits)
//  out_     master     tdata: color_index (8 bits), one beat per pixel
//  cfg_     write      cfg_addr 0: mode, 1: palette_size (no read-back)
//
// One beat enters per cycle while in_tready is high. Each beat walks a row of
// PAL_DEPTH cells, one cell per cycle while the row advances, then the luma
// stage and the output register.
// Palette writes ride the same row, so every pixel sees exactly the entries
// written before it. Write beats produce no output beat.
// Reset is synchronous and active low; it empties the row, holds in_tready
// low and sets mode to palette search and palette_size to 256. Palette
// contents are not reset.
// A stall on the output freezes the whole row; a bubble in the luma stage
// lets the row keep moving while a result waits in the output register.
// ----------------------------------------------------------------------------
module nearest_palette_color_quantizer (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // entry, red, green, blue
  input  logic                            in_tuser,   // kind
  // Result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // color_index
  // Configuration port
  input  logic                            cfg_we,
  input  logic [npq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [npq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                         mode_r;
  logic [npq_pkg::SIZE_W-1:0]   palette_size_r;
  logic                         adv;

  // Beats between cells: slot 0 is the input, slot PAL_DEPTH the row's end.
  logic [npq_pkg::PAL_DEPTH:0]  link_valid;
  npq_pkg::link_t               link [npq_pkg::PAL_DEPTH+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= npq_pkg::MODE_PALETTE;
      palette_size_r <= npq_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        npq_pkg::CFG_MODE: mode_r         <= cfg_wdata[0];
        npq_pkg::CFG_SIZE: palette_size_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The first cell sees the raw input beat with an empty best match, so a
  // palette_size of zero leaves index zero as the answer.
  assign link_valid[0] = in_tvalid && rst_n;
  assign link[0] = '{
    kind:      npq_pkg::kind_t'(in_tuser),
    entry:     in_tdata[7:0],
    red:       in_tdata[15:8],
    green:     in_tdata[23:16],
    blue:      in_tdata[31:24],
    best_idx:  '0,
    best_dist: '0
  };

  for (genvar gi = 0; gi < npq_pkg::PAL_DEPTH; gi++) begin : g_cell
    npq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .adv          (adv),
      .cell_idx     (npq_pkg::IDX_W'(gi)),
      .palette_size (palette_size_r),
      .in_valid     (link_valid[gi]),
      .in_link      (link[gi]),
      .out_valid    (link_valid[gi+1]),
      .out_link     (link[gi+1])
    );
  end

  npq_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .in_valid   (link_valid[npq_pkg::PAL_DEPTH]),
    .in_link    (link[npq_pkg::PAL_DEPTH]),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // The row only ever waits for a result that the output cannot hand off.
  assign in_tready = adv && rst_n;

  // A gray result is one of sixteen levels.
  a_gray_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (mode_r == npq_pkg::MODE_GRAY) |-> out_tdata < 8'd16)
    else $error("gray level out of range");

  // A palette result lies inside the searched part of the palette, or is index zero.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (mode_r == npq_pkg::MODE_PALETTE) |->
      (npq_pkg::SIZE_W'(out_tdata) < palette_size_r) || (out_tdata == 8'd0))
    else $error("palette index beyond palette size");

  // Input is refused only while a finished result is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

endmodule
